// ===== sv/pbsc_pkg.sv =====
package pbsc_pkg;

    localparam int FRAME_W     = 16;
    localparam int FRAC_W      = 16;
    localparam int DEBT_W      = 32;
    localparam int PLAYED_W    = 48;
    localparam int STATE_W     = 3;
    localparam int OP_W        = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 88;

    localparam int SAMPLE_RATE_DEFAULT = 44100;

    localparam logic [FRAME_W-1:0] TARGET_RESET = 16'd441;

    // Register indexes, taken from paddr[2].
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_START  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RESUME  = 3'd0,
        OP_DRAIN   = 3'd1,
        OP_DISCARD = 3'd2,
        OP_AVAIL   = 3'd3,
        OP_STOP    = 3'd4,
        OP_TICK    = 3'd5,
        OP_WRITTEN = 3'd6
    } op_t;

    typedef enum logic [4:0] {
        MODE_PLAYING   = 5'b00001,
        MODE_DRAINING  = 5'b00010,
        MODE_SUSPENDED = 5'b00100,
        MODE_UNDERRUN  = 5'b01000,
        MODE_STOPPED   = 5'b10000
    } mode_t;

    localparam logic [STATE_W-1:0] ST_PLAYING   = 3'd0;
    localparam logic [STATE_W-1:0] ST_DRAINING  = 3'd1;
    localparam logic [STATE_W-1:0] ST_SUSPENDED = 3'd2;
    localparam logic [STATE_W-1:0] ST_UNDERRUN  = 3'd3;
    localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [DEBT_W-1:0]  elapsed_frames_q16;
        logic [FRAME_W-1:0] delivered_frames;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0]  stream_state;
        logic [FRAME_W-1:0]  buffered_count;
        logic [FRAME_W-1:0]  request_frames;
        logic                drain_done;
        logic                rejected;
        logic [PLAYED_W-1:0] played_total;
    } result_t;

    typedef struct packed {
        logic [FRAME_W-1:0] target_buffer_frames;
        logic               start_playing;
        logic               load_mode;
    } cfg_ctl_t;

    function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
        logic [STATE_W-1:0] c;
        unique case (m)
            MODE_PLAYING:   c = ST_PLAYING;
            MODE_DRAINING:  c = ST_DRAINING;
            MODE_SUSPENDED: c = ST_SUSPENDED;
            MODE_UNDERRUN:  c = ST_UNDERRUN;
            MODE_STOPPED:   c = ST_STOPPED;
            default:        c = ST_SUSPENDED;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/pbsc_apb_regs.sv =====
module pbsc_apb_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pbsc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pbsc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pbsc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output pbsc_pkg::cfg_ctl_t                 cfg
);

    logic [pbsc_pkg::FRAME_W-1:0] target_reg;
    logic [pbsc_pkg::FRAME_W-1:0] target_next;
    logic                         start_reg;
    logic                         start_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        target_next = target_reg;
        start_next  = start_reg;
        if (wr_en)
        begin
            if (paddr[2] == pbsc_pkg::REG_TARGET)
            begin
                target_next = pwdata[pbsc_pkg::FRAME_W-1:0];
            end
            else
            begin
                start_next = pwdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pbsc_pkg::TARGET_RESET;
            start_reg  <= 1'b0;
        end
        else
        begin
            target_reg <= target_next;
            start_reg  <= start_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == pbsc_pkg::REG_TARGET)
        begin
            prdata = {{(pbsc_pkg::APB_DATA_W-pbsc_pkg::FRAME_W){1'b0}}, target_reg};
        end
        else
        begin
            prdata = {{(pbsc_pkg::APB_DATA_W-1){1'b0}}, start_reg};
        end
    end

    // Writing start_playing reloads the mode in the same edge as the register.
    assign cfg.target_buffer_frames = target_reg;
    assign cfg.start_playing        = pwdata[0];
    assign cfg.load_mode            = wr_en && (paddr[2] == pbsc_pkg::REG_START);

endmodule

// ===== sv/pbsc_update.sv =====
module pbsc_update
#(
    parameter int SAMPLE_RATE = pbsc_pkg::SAMPLE_RATE_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbsc_pkg::cfg_ctl_t   cfg,
    input  logic                 item_valid,
    input  pbsc_pkg::item_t      item,
    output pbsc_pkg::result_t    result
);

    localparam int FW = pbsc_pkg::FRAME_W;
    localparam int DW = pbsc_pkg::DEBT_W;
    localparam int QW = pbsc_pkg::FRAC_W;
    localparam int PW = pbsc_pkg::PLAYED_W;
    localparam logic [DW:0] DebtCap = (DW+1)'(SAMPLE_RATE) << QW;

    pbsc_pkg::mode_t mode_reg, mode_next;
    logic [FW-1:0]   buffered_reg, buffered_next;
    logic [DW-1:0]   debt_reg, debt_next;
    logic [PW-1:0]   played_reg, played_next;
    logic [FW-1:0]   last_req_reg, last_req_next;

    logic [DW:0]     debt_sum;
    logic [DW-1:0]   debt_capped;
    logic [FW-1:0]   whole;
    logic [FW-1:0]   consumed;
    logic [FW-1:0]   buf_after;
    logic [FW-1:0]   got;
    logic [FW:0]     fill_sum;
    logic [FW-1:0]   fill_sat;
    logic [FW-1:0]   req;
    logic            done;
    logic            rej;
    logic            stopped;
    logic            running;

    assign stopped = (mode_reg == pbsc_pkg::MODE_STOPPED);
    assign running = (mode_reg == pbsc_pkg::MODE_PLAYING)
                  || (mode_reg == pbsc_pkg::MODE_DRAINING);

    // Tick datapath: accrue debt, cap at one second, consume what is buffered.
    always_comb
    begin
        debt_sum    = {1'b0, debt_reg} + {1'b0, item.elapsed_frames_q16};
        debt_capped = (debt_sum > DebtCap) ? DebtCap[DW-1:0] : debt_sum[DW-1:0];
        whole       = debt_capped[DW-1:QW];
        consumed    = (whole < buffered_reg) ? whole : buffered_reg;
        buf_after   = buffered_reg - consumed;
    end

    // Data-written datapath: delivery limited to the request, sum saturates.
    always_comb
    begin
        got      = (item.delivered_frames < last_req_reg) ? item.delivered_frames
                                                          : last_req_reg;
        fill_sum = {1'b0, buffered_reg} + {1'b0, got};
        fill_sat = fill_sum[FW] ? {FW{1'b1}} : fill_sum[FW-1:0];
    end

    always_comb
    begin
        mode_next     = mode_reg;
        buffered_next = buffered_reg;
        debt_next     = debt_reg;
        played_next   = played_reg;
        last_req_next = last_req_reg;
        req           = '0;
        done          = 1'b0;
        rej           = 1'b0;

        unique case (pbsc_pkg::op_t'(item.operation))
            pbsc_pkg::OP_RESUME:
            begin
                if (stopped)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    mode_next = pbsc_pkg::MODE_PLAYING;
                    debt_next = '0;
                end
            end
            pbsc_pkg::OP_DRAIN:
            begin
                if (stopped)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    mode_next = pbsc_pkg::MODE_DRAINING;
                end
            end
            pbsc_pkg::OP_DISCARD:
            begin
                if (stopped)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    buffered_next = '0;
                    mode_next     = pbsc_pkg::MODE_SUSPENDED;
                end
            end
            pbsc_pkg::OP_AVAIL:
            begin
                if (mode_reg == pbsc_pkg::MODE_UNDERRUN)
                begin
                    mode_next = pbsc_pkg::MODE_PLAYING;
                    debt_next = '0;
                end
            end
            pbsc_pkg::OP_STOP:
            begin
                mode_next = pbsc_pkg::MODE_STOPPED;
            end
            pbsc_pkg::OP_TICK:
            begin
                last_req_next = '0;
                if (running)
                begin
                    buffered_next = buf_after;
                    debt_next     = debt_capped - {consumed, {QW{1'b0}}};
                    played_next   = played_reg + {{(PW-FW){1'b0}}, consumed};
                    if (mode_reg == pbsc_pkg::MODE_DRAINING && buf_after == '0)
                    begin
                        mode_next = pbsc_pkg::MODE_SUSPENDED;
                        done      = 1'b1;
                    end
                    else if (mode_reg == pbsc_pkg::MODE_PLAYING
                             && buf_after < cfg.target_buffer_frames)
                    begin
                        last_req_next = cfg.target_buffer_frames - buf_after;
                        req           = cfg.target_buffer_frames - buf_after;
                    end
                end
            end
            pbsc_pkg::OP_WRITTEN:
            begin
                if (last_req_reg != '0)
                begin
                    last_req_next = '0;
                    if (mode_reg == pbsc_pkg::MODE_PLAYING)
                    begin
                        buffered_next = fill_sat;
                        if (got == '0 && fill_sat == '0)
                        begin
                            mode_next = pbsc_pkg::MODE_UNDERRUN;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pbsc_pkg::MODE_SUSPENDED;
            buffered_reg <= '0;
            debt_reg     <= '0;
            played_reg   <= '0;
            last_req_reg <= '0;
        end
        else if (cfg.load_mode)
        begin
            mode_reg <= cfg.start_playing ? pbsc_pkg::MODE_PLAYING
                                          : pbsc_pkg::MODE_SUSPENDED;
            debt_reg <= '0;
        end
        else if (item_valid)
        begin
            mode_reg     <= mode_next;
            buffered_reg <= buffered_next;
            debt_reg     <= debt_next;
            played_reg   <= played_next;
            last_req_reg <= last_req_next;
        end
    end

    assign result.stream_state   = pbsc_pkg::mode_code(mode_next);
    assign result.buffered_count = buffered_next;
    assign result.request_frames = req;
    assign result.drain_done     = done;
    assign result.rejected       = rej;
    assign result.played_total   = played_next;

endmodule

// ===== sv/playback_buffer_state_controller.sv =====
// Playback buffer state controller. Each word on the input stream is one event
// (resume, drain, discard, data available, stop, tick, data written) and yields
// exactly one result word with the stream mode, the buffered frame count, any
// refill request, the drain-done and rejected flags and the 48-bit played total.
// A new word is accepted every cycle unless the input stalls, as described below;
// it is held in the input register, then its result word is registered in the
// result register and presented on the output, with all state updated by a single
// combinational pass in between. The result register is separate from the input
// register, so one more word is taken while a result waits for the sink; after
// that the input stalls until the sink takes the result. Configuration is written
// through the APB port: target_buffer_frames at address 0 and start_playing at
// address 4, where a write of start_playing also reloads the mode and clears the
// frame debt.
module playback_buffer_state_controller
#(
    parameter int SAMPLE_RATE = pbsc_pkg::SAMPLE_RATE_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pbsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pbsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[2:0], elapsed_frames_q16[34:3], delivered_frames[50:35], zero pad
    input  logic [pbsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // stream_state[2:0], buffered_count[18:3], request_frames[34:19],
    // drain_done[35], rejected[36], played_total[84:37], zero pad
    output logic [pbsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int RES_W = $bits(pbsc_pkg::result_t);

    pbsc_pkg::cfg_ctl_t cfg;
    pbsc_pkg::item_t    in_item_reg;
    pbsc_pkg::item_t    in_item_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    pbsc_pkg::result_t  res_comb;
    pbsc_pkg::result_t  out_res_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               in_take;

    pbsc_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbsc_update #(.SAMPLE_RATE(SAMPLE_RATE)) u_update
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (res_comb)
    );

    // The held word moves on when the result register is empty or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item_next.operation          = s_axis_tdata[2:0];
        in_item_next.elapsed_frames_q16 = s_axis_tdata[34:3];
        in_item_next.delivered_frames   = s_axis_tdata[50:35];
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item_next;
        end
        if (advance)
        begin
            out_res_reg <= res_comb;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pbsc_pkg::OUT_TDATA_W-RES_W){1'b0}},
                            out_res_reg.played_total,
                            out_res_reg.rejected,
                            out_res_reg.drain_done,
                            out_res_reg.request_frames,
                            out_res_reg.buffered_count,
                            out_res_reg.stream_state};

endmodule

// ===== dv/playback_buffer_state_controller_tb.sv =====
`timescale 1ns / 100ps

module playback_buffer_state_controller_tb;
    import pbsc_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 7;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          PHASE_WORDS    = 95;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [31:0] MAX_ELAPSED    = 32'hAC44_0000;
    localparam logic [33:0] DEBT_CAP       = 34'(SAMPLE_RATE_DEFAULT) << FRAC_W;
    localparam logic [2:0]  OP_UNUSED      = 3'd7;
    localparam logic [2:0]  ADDR_TARGET    = 3'd0;
    localparam logic [2:0]  ADDR_START     = 3'd4;

    typedef struct packed {
        logic [STATE_W-1:0]  stream_state;
        logic [FRAME_W-1:0]  buffered_count;
        logic [FRAME_W-1:0]  request_frames;
        logic                drain_done;
        logic                rejected;
        logic [PLAYED_W-1:0] played_total;
    } stream_report_t;

    class buffer_scoreboard;
        logic [FRAME_W-1:0]  target;
        bit                  start_playing;
        logic [STATE_W-1:0]  mode;
        logic [FRAME_W-1:0]  buffered;
        logic [33:0]         debt_q16;
        logic [PLAYED_W-1:0] played;
        logic [FRAME_W-1:0]  outstanding;
        stream_report_t      expected_reports[$];
        int                  errors;
        int                  events_noted;
        int                  reports_checked;
        int                  underruns;
        int                  drains_done;
        int                  rejects;
        int                  refills;
        int                  debt_caps;

        function new();
            target = TARGET_RESET;
            start_playing = 1'b0;
            buffered = '0;
            played = '0;
            outstanding = '0;
            load_mode();
        endfunction

        function void load_mode();
            mode = start_playing ? ST_PLAYING : ST_SUSPENDED;
            debt_q16 = '0;
        endfunction

        function void write_reg(logic idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_TARGET)
                target = value[FRAME_W-1:0];
            else
            begin
                start_playing = value[0];
                load_mode();
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void play_tick(logic [31:0] elapsed, ref stream_report_t r);
            logic [33:0]        sum;
            logic [17:0]        whole;
            logic [FRAME_W-1:0] consumed;
            if (mode != ST_PLAYING && mode != ST_DRAINING)
            begin
                outstanding = '0;
                return;
            end
            sum = debt_q16 + 34'(elapsed);
            if (sum > DEBT_CAP)
            begin
                sum = DEBT_CAP;
                debt_caps++;
            end
            debt_q16 = sum;
            whole = debt_q16[33:FRAC_W];
            consumed = (whole < 18'(buffered)) ? whole[FRAME_W-1:0] : buffered;
            buffered = buffered - consumed;
            debt_q16 = debt_q16 - (34'(consumed) << FRAC_W);
            played = played + PLAYED_W'(consumed);
            outstanding = '0;
            if (mode == ST_DRAINING && buffered == 0)
            begin
                mode = ST_SUSPENDED;
                r.drain_done = 1'b1;
                drains_done++;
            end
            else if (mode == ST_PLAYING && buffered < target)
            begin
                outstanding = target - buffered;
                r.request_frames = outstanding;
                refills++;
            end
        endfunction

        function void take_delivery(logic [FRAME_W-1:0] written);
            logic [FRAME_W-1:0] got;
            logic [FRAME_W:0]   fill;
            if (outstanding == 0)
                return;
            got = (written < outstanding) ? written : outstanding;
            outstanding = '0;
            if (mode != ST_PLAYING)
                return;
            fill = {1'b0, buffered} + {1'b0, got};
            buffered = fill[FRAME_W] ? '1 : fill[FRAME_W-1:0];
            if (got == 0 && buffered == 0)
            begin
                mode = ST_UNDERRUN;
                underruns++;
            end
        endfunction

        function void note_event(logic [OP_W-1:0] op, logic [31:0] elapsed,
                                 logic [FRAME_W-1:0] written);
            stream_report_t r;
            r = '0;
            case (op)
                OP_RESUME:
                    if (mode == ST_STOPPED)
                        r.rejected = 1'b1;
                    else
                    begin
                        mode = ST_PLAYING;
                        debt_q16 = '0;
                    end
                OP_DRAIN:
                    if (mode == ST_STOPPED)
                        r.rejected = 1'b1;
                    else
                        mode = ST_DRAINING;
                OP_DISCARD:
                    if (mode == ST_STOPPED)
                        r.rejected = 1'b1;
                    else
                    begin
                        buffered = '0;
                        mode = ST_SUSPENDED;
                    end
                OP_AVAIL:
                    if (mode == ST_UNDERRUN)
                    begin
                        mode = ST_PLAYING;
                        debt_q16 = '0;
                    end
                OP_STOP:    mode = ST_STOPPED;
                OP_TICK:    play_tick(elapsed, r);
                OP_WRITTEN: take_delivery(written);
                default:    ;
            endcase
            if (r.rejected)
                rejects++;
            r.stream_state = mode;
            r.buffered_count = buffered;
            r.played_total = played;
            expected_reports.push_back(r);
            events_noted++;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 40)
                $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        task check_report(logic [OUT_TDATA_W-1:0] d);
            stream_report_t want;
            if (expected_reports.size() == 0)
            begin
                report("result word with nothing expected", d[63:0], 64'd0);
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            if (d[2:0] !== want.stream_state)
                report("stream_state", 64'(d[2:0]), 64'(want.stream_state));
            if (d[18:3] !== want.buffered_count)
                report("buffered_count", 64'(d[18:3]), 64'(want.buffered_count));
            if (d[34:19] !== want.request_frames)
                report("request_frames", 64'(d[34:19]), 64'(want.request_frames));
            if (d[35] !== want.drain_done)
                report("drain_done", 64'(d[35]), 64'(want.drain_done));
            if (d[36] !== want.rejected)
                report("rejected", 64'(d[36]), 64'(want.rejected));
            if (d[84:37] !== want.played_total)
                report("played_total", 64'(d[84:37]), 64'(want.played_total));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    buffer_scoreboard board = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    playback_buffer_state_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The sink decides tready at each falling edge; a pending hold-off wins over random stalls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            board.check_report(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] timeout: no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, board.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_event(input logic [OP_W-1:0] op, input logic [31:0] elapsed,
                              input logic [FRAME_W-1:0] written);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, written, elapsed, op};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        board.note_event(op, elapsed, written);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] want;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (wr)
            board.write_reg(addr[2], data);
        else
        begin
            want = (addr[2] == REG_TARGET) ? APB_DATA_W'(board.target)
                                           : APB_DATA_W'(board.start_playing);
            if ((prdata & data) !== want)
                board.report("register readback", 64'(prdata & data), 64'(want));
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lets the pipeline empty so a register write cannot overlap a word in flight.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [FRAME_W-1:0] target, input bit start);
        apb_access(1'b1, ADDR_TARGET, APB_DATA_W'(target));
        apb_access(1'b1, ADDR_START, APB_DATA_W'(start));
        apb_access(1'b0, ADDR_TARGET, 32'h0000_FFFF);
        apb_access(1'b0, ADDR_START, 32'h0000_0001);
    endtask

    task automatic random_burst(input int count);
        int          pick;
        logic [2:0]  op;
        logic [31:0] elapsed;
        logic [15:0] written;
        longint      span;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            elapsed = $urandom();
            written = 16'($urandom());
            if (pick < 36)
            begin
                op = OP_TICK;
                pick = $urandom_range(0, 99);
                span = (longint'(board.target) + 50) << FRAC_W;
                if (span > MAX_ELAPSED)
                    span = MAX_ELAPSED;
                if (pick < 55)
                    elapsed = $urandom_range(0, 32'(span));
                else if (pick < 85)
                    elapsed = $urandom_range(0, 64 << FRAC_W);
                else
                    elapsed = $urandom_range(0, MAX_ELAPSED);
            end
            else if (pick < 68)
            begin
                op = OP_WRITTEN;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    written = '0;
                else if (pick < 25)
                    written = '1;
                else if (pick < 80)
                    written = 16'($urandom_range(0, int'(board.outstanding) + 20));
            end
            else if (pick < 78)
                op = OP_RESUME;
            else if (pick < 83)
                op = OP_DRAIN;
            else if (pick < 87)
                op = OP_DISCARD;
            else if (pick < 92)
                op = OP_AVAIL;
            else if (pick < 96)
                op = OP_UNUSED;
            // Stop sticks until the next start_playing write, so it only comes near the end.
            else if (i > count - 12)
                op = OP_STOP;
            else
                op = OP_RESUME;
            send_event(op, elapsed, written);
        end
    endtask

    initial
    begin
        logic [FRAME_W-1:0] targets[5];
        bit                 starts[5];
        int                 src_pcts[5];
        int                 sink_pcts[5];

        targets = '{16'd1, 16'hFFFF, TARGET_RESET, 16'd0, 16'd0};
        targets[3] = $urandom_range(2, 2000);
        targets[4] = $urandom_range(1, 65535);
        starts = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        src_pcts = '{0, 64, 0, 31, 0};
        sink_pcts = '{0, 0, 64, 31, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through the modes with the reset configuration.
        send_event(OP_UNUSED, MAX_ELAPSED, 16'hFFFF);
        send_event(OP_TICK, MAX_ELAPSED, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'd500);
        send_event(OP_RESUME, 32'h0, 16'h0);
        send_event(OP_TICK, 32'h0, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'hFFFF);
        send_event(OP_TICK, (32'd100 << FRAC_W) | 32'h8000, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'h0);
        send_event(OP_TICK, MAX_ELAPSED, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'h0);
        send_event(OP_TICK, 32'hFFFF_FFFF & MAX_ELAPSED, 16'h0);
        send_event(OP_AVAIL, 32'h0, 16'h0);
        send_event(OP_TICK, 32'h0000_FFFF, 16'h0);
        send_event(OP_DRAIN, 32'h0, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'd200);
        send_event(OP_TICK, 32'h0, 16'h0);
        send_event(OP_RESUME, 32'h0, 16'h0);
        send_event(OP_TICK, 32'h0, 16'h0);
        send_event(OP_WRITTEN, 32'h0, 16'd300);
        send_event(OP_DISCARD, 32'h0, 16'h0);
        send_event(OP_STOP, 32'h0, 16'h0);
        send_event(OP_RESUME, 32'h0, 16'h0);
        send_event(OP_DRAIN, 32'h0, 16'h0);
        send_event(OP_DISCARD, 32'h0, 16'h0);
        send_event(OP_AVAIL, 32'h0, 16'h0);
        send_event(OP_STOP, 32'h0, 16'h0);
        send_event(OP_TICK, MAX_ELAPSED, 16'h0);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            configure(targets[p], starts[p]);
            @(posedge clk);
            src_idle_pct = src_pcts[p];
            sink_stall_pct = sink_pcts[p];
            if (p == 4)
                hold_left = HOLD_CYCLES;
            random_burst(PHASE_WORDS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d events over 5 configurations, %0d results checked, %0d mismatches.",
                 board.events_noted, board.reports_checked, board.errors);
        $display("Refill requests %0d, underruns %0d, finished drains %0d, rejects %0d, debt caps %0d.",
                 board.refills, board.underruns, board.drains_done, board.rejects, board.debt_caps);
        if (board.errors == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== playback_buffer_state_controller.f =====
sv/pbsc_pkg.sv
sv/pbsc_apb_regs.sv
sv/pbsc_update.sv
sv/playback_buffer_state_controller.sv
dv/playback_buffer_state_controller_tb.sv
